@@ rtl/hemd_pkg.sv @@
// ----------------------------------------------------------------------------
// hemd_pkg: shared types and constants for the haptic envelope motor drive
// Field widths, register indexes, drive modes, reset values and the structs
// passed between the drive stages.
// ----------------------------------------------------------------------------
`default_nettype none

package hemd_pkg;

  // Fixed field widths
  localparam int MODE_W    = 2;
  localparam int INTEN_W   = 8;
  localparam int OUT_W     = 8;
  localparam int FRAC_BITS = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PERIOD_W   = 16;
  localparam int DECAY_W    = 16;
  localparam int DEADZONE_W = 8;
  localparam int TICKS_W    = 16;

  // Default envelope integer width
  localparam int DUTY_BITS_DEF = 8;

  // Register reset values
  localparam logic [PERIOD_W-1:0]   ALT_PERIOD_RST = 16'd40;
  localparam logic [DECAY_W-1:0]    DECAY_RST      = 16'd55706;
  localparam logic [DEADZONE_W-1:0] DEADZONE_RST   = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALT_PERIOD = 2'd0,
    CFG_DECAY      = 2'd1,
    CFG_DEADZONE   = 2'd2
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF = 2'd0,
    MODE_FWD = 2'd1,
    MODE_REV = 2'd2,
    MODE_ALT = 2'd3
  } drive_mode_t;

  typedef struct packed {
    logic [PERIOD_W-1:0]   alt_period_ms;
    logic [DECAY_W-1:0]    decay_factor;
    logic [DEADZONE_W-1:0] deadzone;
  } cfg_t;

  typedef struct packed {
    drive_mode_t          drive_mode;
    logic [INTEN_W-1:0]   intensity;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0] forward_duty;
    logic [OUT_W-1:0] reverse_duty;
    logic [OUT_W-1:0] led_duty;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/hemd_in_if.sv @@
// ----------------------------------------------------------------------------
// hemd_in_if: input channel of the haptic envelope motor drive
// Valid/ready handshake carrying drive mode and intensity.
// ----------------------------------------------------------------------------
`default_nettype none

interface hemd_in_if;
  logic                          valid;
  logic                          ready;
  logic [hemd_pkg::MODE_W-1:0]   drive_mode;
  logic [hemd_pkg::INTEN_W-1:0]  intensity;

  modport source (output valid, output drive_mode, output intensity, input ready);
  modport sink   (input valid, input drive_mode, input intensity, output ready);
endinterface

`default_nettype wire

@@ rtl/hemd_out_if.sv @@
// ----------------------------------------------------------------------------
// hemd_out_if: output channel of the haptic envelope motor drive
// Valid/ready handshake carrying forward, reverse and LED duties.
// ----------------------------------------------------------------------------
`default_nettype none

interface hemd_out_if;
  logic                        valid;
  logic                        ready;
  logic [hemd_pkg::OUT_W-1:0]  forward_duty;
  logic [hemd_pkg::OUT_W-1:0]  reverse_duty;
  logic [hemd_pkg::OUT_W-1:0]  led_duty;

  modport source (output valid, output forward_duty, output reverse_duty,
                  output led_duty, input ready);
  modport sink   (input valid, input forward_duty, input reverse_duty,
                  input led_duty, output ready);
endinterface

`default_nettype wire

@@ rtl/hemd_cfg.sv @@
// ----------------------------------------------------------------------------
// hemd_cfg: configuration registers
// Holds period, decay factor and deadzone; written by index, no read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module hemd_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [hemd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hemd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output hemd_pkg::cfg_t                        cfg
);
  import hemd_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.alt_period_ms <= ALT_PERIOD_RST;
      regs.decay_factor  <= DECAY_RST;
      regs.deadzone      <= DEADZONE_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ALT_PERIOD: regs.alt_period_ms <= cfg_data[PERIOD_W-1:0];
        CFG_DECAY:      regs.decay_factor  <= cfg_data[DECAY_W-1:0];
        CFG_DEADZONE:   regs.deadzone      <= cfg_data[DEADZONE_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

@@ rtl/hemd_in_reg.sv @@
// ----------------------------------------------------------------------------
// hemd_in_reg: input register stage
// Captures one input word per cycle; holds it while the next stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module hemd_in_reg (
  input  wire logic    clk,
  input  wire logic    rst,
  hemd_in_if.sink      in_ch,
  input  wire logic    advance,
  output logic         valid,
  output hemd_pkg::item_t item
);
  import hemd_pkg::*;

  logic  valid_next;
  logic  take;

  assign in_ch.ready = !valid || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_next = valid;
    if (take) begin
      valid_next = 1'b1;
    end else if (advance) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.drive_mode <= drive_mode_t'(in_ch.drive_mode);
      item.intensity  <= in_ch.intensity;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hemd_core.sv @@
// ----------------------------------------------------------------------------
// hemd_core: envelope follower and drive routing
// Holds envelope, swap phase and tick count; computes one result per advance.
// ----------------------------------------------------------------------------
`default_nettype none

module hemd_core #(
  parameter int DUTY_BITS = hemd_pkg::DUTY_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire hemd_pkg::item_t  item,
  input  wire hemd_pkg::cfg_t   cfg,
  output hemd_pkg::result_t     result
);
  import hemd_pkg::*;

  localparam int ENV_W  = DUTY_BITS + FRAC_BITS;
  localparam int PROD_W = ENV_W + DECAY_W;
  localparam int EXT_W  = DUTY_BITS + OUT_W;

  logic [ENV_W-1:0]     envelope;
  logic                 alt_phase;
  logic [TICKS_W-1:0]   ticks_since_swap;

  logic [ENV_W-1:0]     envelope_next;
  logic                 alt_phase_next;
  logic [TICKS_W-1:0]   ticks_since_swap_next;

  logic [EXT_W-1:0]     inten_ext;
  logic [EXT_W-1:0]     duty_max_ext;
  logic [DUTY_BITS-1:0] target;
  logic [ENV_W-1:0]     target_fx;
  logic [PROD_W-1:0]    product;
  logic [DUTY_BITS-1:0] duty_raw;
  logic [DUTY_BITS-1:0] duty;
  logic [DUTY_BITS-1:0] fwd;
  logic [DUTY_BITS-1:0] rev;
  logic [DUTY_BITS-1:0] led;
  logic [TICKS_W-1:0]   ticks_inc;
  logic                 swap;
  logic [EXT_W-1:0]     fwd_ext;
  logic [EXT_W-1:0]     rev_ext;
  logic [EXT_W-1:0]     led_ext;

  always_comb begin
    // Target: intensity clipped to the duty range, zero when off
    inten_ext    = {{DUTY_BITS{1'b0}}, item.intensity};
    duty_max_ext = {{OUT_W{1'b0}}, {DUTY_BITS{1'b1}}};
    if (item.drive_mode == MODE_OFF) begin
      target = '0;
    end else if (inten_ext > duty_max_ext) begin
      target = '1;
    end else begin
      target = inten_ext[DUTY_BITS-1:0];
    end
    target_fx = {target, {FRAC_BITS{1'b0}}};

    // Instant attack, otherwise truncated decay
    product = PROD_W'(envelope) * PROD_W'(cfg.decay_factor);
    if (target_fx > envelope) begin
      envelope_next = target_fx;
    end else begin
      envelope_next = product[PROD_W-1:DECAY_W];
    end

    duty_raw = envelope_next[ENV_W-1:FRAC_BITS];
    if ({{OUT_W{1'b0}}, duty_raw} < {{DUTY_BITS{1'b0}}, cfg.deadzone}) begin
      duty = '0;
    end else begin
      duty = duty_raw;
    end

    // Saturating tick count, swap in alternating mode once past the period
    ticks_inc = (ticks_since_swap == {TICKS_W{1'b1}}) ? ticks_since_swap
                                                     : ticks_since_swap + 1'b1;
    swap = (item.drive_mode == MODE_ALT) && (ticks_inc > cfg.alt_period_ms);
    ticks_since_swap_next = swap ? '0 : ticks_inc;
    alt_phase_next        = alt_phase ^ swap;

    fwd = '0;
    rev = '0;
    unique case (item.drive_mode)
      MODE_OFF: ;
      MODE_FWD: fwd = duty;
      MODE_REV: rev = duty;
      MODE_ALT: begin
        if (alt_phase_next) begin
          fwd = duty;
        end else begin
          rev = duty;
        end
      end
    endcase

    led = {DUTY_BITS{1'b1}} - duty;

    fwd_ext = {{OUT_W{1'b0}}, fwd};
    rev_ext = {{OUT_W{1'b0}}, rev};
    led_ext = {{OUT_W{1'b0}}, led};
    result.forward_duty = fwd_ext[OUT_W-1:0];
    result.reverse_duty = rev_ext[OUT_W-1:0];
    result.led_duty     = led_ext[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      envelope         <= '0;
      alt_phase        <= 1'b0;
      ticks_since_swap <= '0;
    end else if (advance) begin
      envelope         <= envelope_next;
      alt_phase        <= alt_phase_next;
      ticks_since_swap <= ticks_since_swap_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hemd_out_reg.sv @@
// ----------------------------------------------------------------------------
// hemd_out_reg: result register stage
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hemd_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire hemd_pkg::result_t  result,
  output logic                    can_load,
  hemd_out_if.source              out_ch
);
  import hemd_pkg::*;

  logic    valid;
  logic    valid_next;
  result_t data;

  assign can_load = !valid || out_ch.ready;

  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (out_ch.ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

  assign out_ch.valid        = valid;
  assign out_ch.forward_duty = data.forward_duty;
  assign out_ch.reverse_duty = data.reverse_duty;
  assign out_ch.led_duty     = data.led_duty;

endmodule

`default_nettype wire

@@ rtl/haptic_envelope_motor_drive_unit.sv @@
// ----------------------------------------------------------------------------
// haptic_envelope_motor_drive_unit: haptic envelope follower and motor drive
// Peak envelope with instant attack and exponential decay, routed to the
// forward or reverse motor side, with an inverted LED duty.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one word per tick (drive_mode, intensity); a word is taken
//          at a clock edge with valid and ready both high.
//   out_ch returns one word (forward_duty, reverse_duty, led_duty) per input
//          word, in order.
//   cfg_we/cfg_index/cfg_data write alt_period_ms (0), decay_factor (1) and
//          deadzone (2); write only while no word is in flight.
// Path: a word taken on in_ch passes two register stages (input and result
//   register) and reaches out_ch once the result register has room.
// Throughput: one word per cycle unless out_ch stalls; the envelope update,
//   single envelope-by-decay multiply and routing sit between the registers.
// Reset: envelope, swap phase and tick count clear, registers take their
//   defaults, both stages empty. No clearing pass.
// Stall: with out_ch.ready low the result holds; one more word can sit in the
//   input register, after which in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module haptic_envelope_motor_drive_unit #(
  parameter int DUTY_BITS = hemd_pkg::DUTY_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  hemd_in_if.sink                               in_ch,
  hemd_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [hemd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hemd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hemd_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t result;
  logic    item_valid;
  logic    can_load;
  logic    advance;

  // Move the held word into the result register when there is room
  assign advance = item_valid && can_load;

  hemd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hemd_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .advance (advance),
    .valid   (item_valid),
    .item    (item)
  );

  hemd_core #(
    .DUTY_BITS (DUTY_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  hemd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

@@ rtl/hemd_checker.sv @@
// ----------------------------------------------------------------------------
// hemd_checker: port-level checks for the haptic envelope motor drive
// Watches the channel ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hemd_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_ready,
  input  wire logic                         out_valid,
  input  wire logic                         out_ready,
  input  wire logic [hemd_pkg::OUT_W-1:0]   forward_duty,
  input  wire logic [hemd_pkg::OUT_W-1:0]   reverse_duty,
  input  wire logic [hemd_pkg::OUT_W-1:0]   led_duty
);
  import hemd_pkg::*;

  // Result register empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  // A stalled result word holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(forward_duty) && $stable(reverse_duty) && $stable(led_duty)))
    else $error("stalled result word changed");

  // Input backpressure only comes from a stalled, full result register
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input not ready without output stall");

  // The motor is never driven on both sides at once
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (forward_duty == '0 || reverse_duty == '0))
    else $error("both motor sides driven");

endmodule

bind haptic_envelope_motor_drive_unit hemd_checker u_hemd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .forward_duty (out_ch.forward_duty),
  .reverse_duty (out_ch.reverse_duty),
  .led_duty     (out_ch.led_duty)
);

`default_nettype wire
